/* rtl/core/sird_pkg.sv */
// ----------------------------------------------------------------------------
// Signed integer to radix digits: shared definitions
// Constants, register indexes, state codes and the alphabet lookup used by
// the conversion block.
// ----------------------------------------------------------------------------
package sird_pkg;

  localparam int VALUE_W        = 32;
  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_RADIX_DEF  = 16;

  localparam int CFG_RADIX_W = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;

  localparam int SYMBOL_W    = 8;
  localparam int SYM_COUNT   = 16;
  localparam int SYM_IDX_W   = 4;
  localparam int SYMS_W      = SYM_COUNT * SYMBOL_W;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_RADIX_W-1:0] RADIX_RESET   = 5'd10;
  localparam logic [CFG_DATA_W-1:0]  SYMS_LO_RESET = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0]  SYMS_HI_RESET = 64'h6665_6463_6261_3938;
  localparam logic [SYMBOL_W-1:0]    MINUS_BYTE    = 8'h2D;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RADIX   = 2'd0,
    REG_SYMS_LO = 2'd1,
    REG_SYMS_HI = 2'd2
  } sird_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } sird_state_e;

  function automatic logic [SYMBOL_W-1:0] lookup_symbol(
    input logic [SYMS_W-1:0]    syms,
    input logic [SYM_IDX_W-1:0] idx
  );
    return syms[{idx, 3'b000} +: SYMBOL_W];
  endfunction

endpackage

/* rtl/core/sird_front.sv */
// ----------------------------------------------------------------------------
// Signed integer to radix digits: front end
// Accepts input requests and splits each value into a sign flag and an
// unsigned magnitude, held in a register stage ahead of the queue.
// ----------------------------------------------------------------------------
module sird_front #(
  parameter int VALUE_BITS = sird_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sird_pkg::VALUE_W-1:0] value_i,
  output logic                         item_valid_o,
  input  logic                         item_ready_i,
  output logic [VALUE_BITS:0]          item_data_o
);

  logic                  valid_q, valid_d;
  logic                  neg_q, neg_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [VALUE_BITS-1:0] raw;
  logic                  accept;

  assign raw        = value_i[VALUE_BITS-1:0];
  assign in_stall_o = valid_q && !item_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q && !item_ready_i;
    neg_d   = neg_q;
    mag_d   = mag_q;
    if (accept) begin
      valid_d = 1'b1;
      neg_d   = raw[VALUE_BITS-1];
      mag_d   = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
  end

  assign item_valid_o = valid_q;
  assign item_data_o  = {neg_q, mag_q};

endmodule

/* rtl/core/sird_queue.sv */
// ----------------------------------------------------------------------------
// Signed integer to radix digits: request queue
// A small first-in first-out buffer between the front end and the digit
// converter, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module sird_queue #(
  parameter int WIDTH = sird_pkg::VALUE_BITS_DEF + 1,
  parameter int DEPTH = sird_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = count_q != CNT_W'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/core/sird_back.sv */
// ----------------------------------------------------------------------------
// Signed integer to radix digits: digit converter
// Divides the magnitude by the radix once per digit through a reciprocal
// multiply with one correction step, stacks the digits and then sends the
// sign and the digits, most significant first, through an output register.
// ----------------------------------------------------------------------------
module sird_back #(
  parameter int VALUE_BITS = sird_pkg::VALUE_BITS_DEF,
  parameter int MAX_RADIX  = sird_pkg::MAX_RADIX_DEF,
  localparam int RADIX_W   = $clog2(MAX_RADIX + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_valid_i,
  output logic                          item_ready_o,
  input  logic [VALUE_BITS:0]           item_data_i,
  input  logic [RADIX_W-1:0]            radix_i,
  input  logic [sird_pkg::SYMS_W-1:0]   symbols_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sird_pkg::SYMBOL_W-1:0] symbol_o,
  output logic                          last_o
);

  localparam int DIGIT_W = $clog2(MAX_RADIX);
  localparam int REM_W   = $clog2(2 * MAX_RADIX);
  localparam int SMAX    = $clog2(MAX_RADIX + 1) - 1;
  localparam int SH_W    = (SMAX > 0) ? $clog2(SMAX + 1) : 1;
  localparam int CNT_W   = $clog2(VALUE_BITS + 1);
  localparam int PROD_W  = 2 * VALUE_BITS;

  sird_pkg::sird_state_e state_q, state_d;

  logic [VALUE_BITS-1:0]         num_q, num_d;
  logic                          neg_q, neg_d;
  logic [PROD_W-1:0]             prod_q, prod_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          sign_pend_q, sign_pend_d;
  logic [DIGIT_W-1:0]            stack_q [VALUE_BITS];
  logic                          out_valid_q, out_valid_d;
  logic [sird_pkg::SYMBOL_W-1:0] symbol_q, symbol_d;
  logic                          last_q, last_d;

  logic [VALUE_BITS-1:0] recip_tbl [MAX_RADIX + 1];
  logic [SH_W-1:0]       shift_tbl [MAX_RADIX + 1];
  logic [VALUE_BITS-1:0] recip_sel;
  logic [SH_W-1:0]       shift_sel;
  logic [VALUE_BITS-1:0] q_est, quot;
  logic [2*REM_W-1:0]    qr;
  logic [REM_W-1:0]      rem, rem_fix;
  logic                  fix;
  logic [DIGIT_W-1:0]    digit;
  logic                  push, pop, load_ok;

  for (genvar g = 0; g <= MAX_RADIX; g++) begin : g_rcp
    if (g < 2) begin : g_none
      assign recip_tbl[g] = '0;
      assign shift_tbl[g] = '0;
    end else begin : g_div
      localparam int G = g;
      localparam int S = $clog2(G + 1) - 1;
      localparam logic [63:0] NUM = (64'd1 << (VALUE_BITS + S)) - 64'd1;
      localparam logic [63:0] RCP = NUM / G;
      assign recip_tbl[g] = RCP[VALUE_BITS-1:0];
      assign shift_tbl[g] = SH_W'(S);
    end
  end

  assign recip_sel = recip_tbl[radix_i];
  assign shift_sel = shift_tbl[radix_i];

  // The estimate is the true quotient or one below it.
  assign q_est   = prod_q[PROD_W-1:VALUE_BITS] >> shift_sel;
  assign qr      = (2 * REM_W)'(q_est[REM_W-1:0]) * (2 * REM_W)'(radix_i);
  assign rem     = num_q[REM_W-1:0] - qr[REM_W-1:0];
  assign fix     = rem >= REM_W'(radix_i);
  assign rem_fix = fix ? (rem - REM_W'(radix_i)) : rem;
  assign digit   = rem_fix[DIGIT_W-1:0];
  assign quot    = fix ? (q_est + VALUE_BITS'(1)) : q_est;
  assign load_ok = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    num_d       = num_q;
    neg_d       = neg_q;
    prod_d      = prod_q;
    cnt_d       = cnt_q;
    sign_pend_d = sign_pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    symbol_d    = symbol_q;
    last_d      = last_q;
    push        = 1'b0;
    pop         = 1'b0;
    case (state_q)
      sird_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          neg_d   = item_data_i[VALUE_BITS];
          num_d   = item_data_i[VALUE_BITS-1:0];
          cnt_d   = '0;
          state_d = sird_pkg::ST_MUL;
        end
      end
      sird_pkg::ST_MUL: begin
        prod_d  = PROD_W'(num_q) * PROD_W'(recip_sel);
        state_d = sird_pkg::ST_DIV;
      end
      sird_pkg::ST_DIV: begin
        push  = 1'b1;
        cnt_d = cnt_q + CNT_W'(1);
        num_d = quot;
        if (quot == '0) begin
          sign_pend_d = neg_q;
          state_d     = sird_pkg::ST_EMIT;
        end else begin
          state_d = sird_pkg::ST_MUL;
        end
      end
      sird_pkg::ST_EMIT: begin
        if (load_ok) begin
          out_valid_d = 1'b1;
          if (sign_pend_q) begin
            symbol_d    = sird_pkg::MINUS_BYTE;
            last_d      = 1'b0;
            sign_pend_d = 1'b0;
          end else begin
            symbol_d = sird_pkg::lookup_symbol(symbols_i,
                                               sird_pkg::SYM_IDX_W'(stack_q[0]));
            last_d   = cnt_q == CNT_W'(1);
            pop      = 1'b1;
            cnt_d    = cnt_q - CNT_W'(1);
            if (cnt_q == CNT_W'(1)) begin
              state_d = sird_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = sird_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sird_pkg::ST_IDLE;
      cnt_q       <= '0;
      sign_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sign_pend_q <= sign_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q    <= num_d;
    neg_q    <= neg_d;
    prod_q   <= prod_d;
    symbol_q <= symbol_d;
    last_q   <= last_d;
  end

  // Digits are pushed least significant first, so the top holds the next one out.
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_q[0] <= digit;
      for (int i = 1; i < VALUE_BITS; i++) begin
        stack_q[i] <= stack_q[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        stack_q[i] <= stack_q[i+1];
      end
    end
  end

  assign item_ready_o = state_q == sird_pkg::ST_IDLE;
  assign out_valid_o  = out_valid_q;
  assign symbol_o     = symbol_q;
  assign last_o       = last_q;

endmodule

/* rtl/core/signed_integer_to_radix_digits_top.sv */
// ----------------------------------------------------------------------------
// Signed integer to radix digits
// Converts a signed integer to its text in a configurable radix and alphabet,
// one character per output request, most significant digit first.
//
// The input channel (in_valid_i, in_stall_o, value_i) takes one value per
// request. The output channel (out_valid_o, out_stall_i, symbol_o, last_o)
// gives a minus byte for negative values, then the digits; last_o marks the
// final character. The write channel (cfg_valid_i, cfg_ready_o, cfg_index_i,
// cfg_data_i) sets the radix and the two alphabet halves, and is always ready.
// A value occupies the converter while it is taken from the queue, divided
// with one reciprocal multiply and one correction per digit, and sent one
// character at a time. A front register and a two-entry queue hold later
// requests while a value is converted. Reset empties the queue and restores
// radix ten with the alphabet of digits and lower-case letters. While the
// receiver stalls, the held character stays put and the converter waits
// before sending the next one.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_digits_top #(
  parameter int VALUE_BITS = sird_pkg::VALUE_BITS_DEF,
  parameter int MAX_RADIX  = sird_pkg::MAX_RADIX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [sird_pkg::VALUE_W-1:0]     value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [sird_pkg::SYMBOL_W-1:0]    symbol_o,
  output logic                             last_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sird_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [sird_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int RADIX_W = $clog2(MAX_RADIX + 1);

  logic [sird_pkg::CFG_RADIX_W-1:0] radix_q;
  logic [sird_pkg::CFG_DATA_W-1:0]  syms_lo_q;
  logic [sird_pkg::CFG_DATA_W-1:0]  syms_hi_q;
  logic [RADIX_W-1:0]               radix_eff;

  logic                  front_valid, front_ready;
  logic [VALUE_BITS:0]   front_data;
  logic                  queue_valid, queue_ready;
  logic [VALUE_BITS:0]   queue_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q   <= sird_pkg::RADIX_RESET;
      syms_lo_q <= sird_pkg::SYMS_LO_RESET;
      syms_hi_q <= sird_pkg::SYMS_HI_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        sird_pkg::REG_RADIX: begin
          radix_q <= cfg_data_i[sird_pkg::CFG_RADIX_W-1:0];
        end
        sird_pkg::REG_SYMS_LO: begin
          syms_lo_q <= cfg_data_i;
        end
        sird_pkg::REG_SYMS_HI: begin
          syms_hi_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (radix_q < sird_pkg::CFG_RADIX_W'(2)) begin
      radix_eff = RADIX_W'(2);
    end else if (radix_q > sird_pkg::CFG_RADIX_W'(MAX_RADIX)) begin
      radix_eff = RADIX_W'(MAX_RADIX);
    end else begin
      radix_eff = RADIX_W'(radix_q);
    end
  end

  sird_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .item_valid_o(front_valid),
    .item_ready_i(front_ready),
    .item_data_o (front_data)
  );

  sird_queue #(
    .WIDTH(VALUE_BITS + 1),
    .DEPTH(sird_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(front_valid),
    .push_ready_o(front_ready),
    .push_data_i (front_data),
    .pop_valid_o (queue_valid),
    .pop_ready_i (queue_ready),
    .pop_data_o  (queue_data)
  );

  sird_back #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_RADIX (MAX_RADIX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(queue_valid),
    .item_ready_o(queue_ready),
    .item_data_i (queue_data),
    .radix_i     (radix_eff),
    .symbols_i   ({syms_hi_q, syms_lo_q}),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .symbol_o    (symbol_o),
    .last_o      (last_o)
  );

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Testbench for the signed integer to radix digits converter
// Each accepted value is turned into its expected character string, one
// entry per output request, and the block's output is compared with it in
// order. A short table of directed values and register writes comes first;
// it covers the extremes, radix saturation and odd alphabets. Random phases
// with fresh radix and alphabet settings follow, with random gaps and stalls
// on both channels, one long output hold-off, and a final phase without gaps.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 600000;

  typedef struct packed {
    logic [sird_pkg::SYMBOL_W-1:0] symbol;
    logic                          last;
  } text_char_t;

  typedef enum logic {ROW_VALUE, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    sird_pkg::sird_reg_e index;
    logic [63:0]         data;
    string               text;
  } stim_row_t;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  logic [sird_pkg::VALUE_W-1:0]    value_i     = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [sird_pkg::SYMBOL_W-1:0]   symbol_o;
  logic                            last_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  sird_pkg::sird_reg_e             cfg_index_i = sird_pkg::REG_RADIX;
  logic [sird_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  logic [sird_pkg::CFG_RADIX_W-1:0] cfg_radix = sird_pkg::RADIX_RESET;
  logic [sird_pkg::SYMS_W-1:0]      alphabet  = {sird_pkg::SYMS_HI_RESET,
                                                 sird_pkg::SYMS_LO_RESET};

  text_char_t pending_text[$];
  string      stated_text[$];
  stim_row_t  script[$];

  int   mismatches  = 0;
  int   cycle_count = 0;
  int   tx_mode     = 0;
  logic quiet       = 1'b0;
  logic hold_req    = 1'b0;

  signed_integer_to_radix_digits_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .symbol_o    (symbol_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int clamp_base(input int code);
    if (code < 2) return 2;
    if (code > 16) return 16;
    return code;
  endfunction

  // Appends the characters of one value, sign first, to the expected text.
  function automatic void format_value(input logic [sird_pkg::VALUE_W-1:0] v);
    logic [sird_pkg::VALUE_W-1:0] magnitude;
    logic [sird_pkg::VALUE_W-1:0] base;
    logic [3:0]                   digits[$];
    magnitude = v[sird_pkg::VALUE_W-1] ? (~v + 1'b1) : v;
    base = clamp_base(int'(cfg_radix));
    do begin
      digits.push_front(4'(magnitude % base));
      magnitude = magnitude / base;
    end while (magnitude != 0);
    if (v[sird_pkg::VALUE_W-1]) begin
      pending_text.push_back(text_char_t'{sird_pkg::MINUS_BYTE, 1'b0});
    end
    foreach (digits[i]) begin
      pending_text.push_back(text_char_t'{8'(alphabet >> (8 * digits[i])),
                                          i == digits.size() - 1});
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    string      stated;
    text_char_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          sird_pkg::REG_RADIX:   cfg_radix = cfg_data_i[sird_pkg::CFG_RADIX_W-1:0];
          sird_pkg::REG_SYMS_LO: alphabet[63:0] = cfg_data_i;
          sird_pkg::REG_SYMS_HI: alphabet[127:64] = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        stated = stated_text.pop_front();
        if (stated.len() != 0) begin
          for (int i = 0; i < stated.len(); i++) begin
            pending_text.push_back(text_char_t'{stated[i], i == stated.len() - 1});
          end
        end else begin
          format_value(value_i);
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_text.size() == 0) begin
          $error("unexpected character: symbol %h, last %b", symbol_o, last_o);
          mismatches++;
        end else begin
          want = pending_text.pop_front();
          if (symbol_o !== want.symbol) begin
            $error("symbol: expected %h, actual %h", want.symbol, symbol_o);
            mismatches++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %b, actual %b", want.last, last_o);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("signed_integer_to_radix_digits_top test failed");
      $finish;
    end
  end

  initial begin : receiver
    int mode;
    int span;
    int burst;
    mode = 0;
    span = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet) begin
        if (span == 0) begin
          mode = $urandom_range(0, 2);
          span = $urandom_range(20, 80);
        end
        span--;
        if (mode != 0 && $urandom_range(0, mode == 1 ? 9 : 2) == 0) begin
          burst = $urandom_range(1, 18);
          out_stall_i <= 1'b1;
          repeat (burst) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  function automatic void add_value(input logic [sird_pkg::VALUE_W-1:0] v,
                                    input string text);
    script.push_back('{ROW_VALUE, sird_pkg::REG_RADIX, {32'h0, v}, text});
  endfunction

  function automatic void add_write(input sird_pkg::sird_reg_e idx,
                                    input logic [63:0] data);
    script.push_back('{ROW_WRITE, idx, data, ""});
  endfunction

  function automatic logic [sird_pkg::VALUE_W-1:0] pick_value(input int base);
    logic [sird_pkg::VALUE_W-1:0] v;
    int                           pick;
    pick = $urandom_range(0, 4);
    case (pick)
      0: v = $urandom;
      1: v = $urandom_range(0, 40);
      2: begin
        v = 1;
        repeat ($urandom_range(1, 31)) v = v * base;
        v = v + $urandom_range(0, 2) - 1;
      end
      3: v = $urandom >> $urandom_range(0, 31);
      default: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    if (pick != 0 && pick != 4 && $urandom_range(0, 1) == 1) v = ~v + 1'b1;
    return v;
  endfunction

  task automatic offer_value(input logic [sird_pkg::VALUE_W-1:0] v, input string text);
    stated_text.push_back(text);
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic pause_input();
    int gap;
    if (quiet || tx_mode == 0) return;
    if ($urandom_range(0, tx_mode == 1 ? 5 : 1) != 0) return;
    gap = $urandom_range(1, 18);
    in_valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic write_reg(input sird_pkg::sird_reg_e idx, input logic [63:0] data);
    in_valid_i <= 1'b0;
    while (pending_text.size() != 0 || stated_text.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : sender
    logic [63:0] word;
    int          radix_code;
    int          base;

    add_value(32'h0000_0000, "0");
    add_value(32'h0000_0001, "1");
    add_value(32'hFFFF_FFFF, "-1");
    add_value(32'h7FFF_FFFF, "2147483647");
    add_value(32'h8000_0000, "-2147483648");
    add_value(32'h0000_000A, "10");
    add_value(32'h5555_5555, "");
    add_value(32'hAAAA_AAAA, "");
    add_write(sird_pkg::REG_RADIX, 64'd16);
    add_value(32'h7FFF_FFFF, "7fffffff");
    add_value(32'h8000_0000, "-80000000");
    add_value(32'h0123_4567, "1234567");
    add_value(32'hFEDC_BA98, "-1234568");
    add_write(sird_pkg::REG_RADIX, 64'd2);
    add_value(32'h8000_0000, "");
    add_value(32'h7FFF_FFFF, "");
    add_value(32'h0000_0005, "101");
    add_write(sird_pkg::REG_RADIX, 64'd0);
    add_value(32'h0000_0006, "110");
    add_write(sird_pkg::REG_RADIX, 64'd1);
    add_value(32'h0000_0003, "11");
    add_write(sird_pkg::REG_RADIX, 64'd17);
    add_value(32'h0000_00FF, "ff");
    add_write(sird_pkg::REG_RADIX, 64'hFFFF_FFFF_FFFF_FFFF);
    add_value(32'hFFFF_FF00, "-100");
    add_write(sird_pkg::REG_SYMS_LO, 64'h2D2D_2D2D_2D2D_2D2D);
    add_write(sird_pkg::REG_SYMS_HI, 64'hFFFF_FFFF_FFFF_FFFF);
    add_value(32'hFFFF_FFFF, "");
    add_value(32'h89AB_CDEF, "");
    add_value(32'h0000_0000, "");
    add_write(sird_pkg::REG_SYMS_LO, 64'h0);
    add_write(sird_pkg::REG_SYMS_HI, 64'h0);
    add_value(32'h0000_3039, "");
    add_write(sird_pkg::REG_RADIX, 64'd7);
    add_write(sird_pkg::REG_SYMS_LO, sird_pkg::SYMS_LO_RESET);
    add_write(sird_pkg::REG_SYMS_HI, sird_pkg::SYMS_HI_RESET);
    add_value(32'h8000_0000, "");
    add_value(32'h0000_03E8, "");

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_mode = $urandom_range(1, 2);
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        write_reg(script[i].index, script[i].data);
      end else begin
        offer_value(script[i].data[sird_pkg::VALUE_W-1:0], script[i].text);
        pause_input();
      end
    end

    for (int phase = 0; phase < 6; phase++) begin
      radix_code = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31)
                                               : $urandom_range(2, 16);
      word = {$urandom, $urandom};
      word[sird_pkg::CFG_RADIX_W-1:0] = radix_code[sird_pkg::CFG_RADIX_W-1:0];
      write_reg(sird_pkg::REG_RADIX, word);
      if (phase == 5) begin
        write_reg(sird_pkg::REG_SYMS_LO, sird_pkg::SYMS_LO_RESET);
        write_reg(sird_pkg::REG_SYMS_HI, sird_pkg::SYMS_HI_RESET);
      end else if ($urandom_range(0, 1) == 1) begin
        write_reg(sird_pkg::REG_SYMS_LO, {$urandom, $urandom});
        write_reg(sird_pkg::REG_SYMS_HI, {$urandom, $urandom});
      end
      base    = clamp_base(radix_code);
      tx_mode = $urandom_range(0, 2);
      if (phase == 2) hold_req = 1'b1;
      if (phase == 5) quiet = 1'b1;
      repeat (16) begin
        offer_value(pick_value(base), "");
        pause_input();
      end
    end

    in_valid_i <= 1'b0;
    while (pending_text.size() != 0 || stated_text.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("signed_integer_to_radix_digits_top test passed");
    end else begin
      $display("signed_integer_to_radix_digits_top test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/sird_pkg.sv
rtl/core/sird_front.sv
rtl/core/sird_queue.sv
rtl/core/sird_back.sv
rtl/core/signed_integer_to_radix_digits_top.sv
tb/tb_top.sv
